// ----- rtl/rdfs_pkg.sv -----
// ============================================================================
// rdfs_pkg - shared definitions for the random depth-first maze generator
// Field widths, register indexes, command and side codes, and the small
// arithmetic helpers used by the walk sequencer.
// ============================================================================
package rdfs_pkg;

	// Default grid limits handed to the top level parameters.
	localparam int MAX_ROWS_DEF    = 16;
	localparam int MAX_COLUMNS_DEF = 16;
	localparam int SIDE_COUNT      = 4;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int COUNT_W     = 5;
	localparam int SEED_W      = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED  = 2'd2;

	localparam logic [COUNT_W-1:0] ROW_COUNT_RST    = 5'd16;
	localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 5'd16;
	localparam logic [SEED_W-1:0]  RANDOM_SEED_RST  = 16'd1;

	// Stream payload widths.
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	// Command codes carried on the input tuser bit.
	localparam logic FUNC_GENERATE = 1'b0;
	localparam logic FUNC_READ     = 1'b1;

	// Side codes, also the bit positions in the wall nibble.
	localparam logic [1:0] SIDE_TOP    = 2'd0;
	localparam logic [1:0] SIDE_LEFT   = 2'd1;
	localparam logic [1:0] SIDE_BOTTOM = 2'd2;
	localparam logic [1:0] SIDE_RIGHT  = 2'd3;

	localparam logic [3:0] WALLS_ALL  = 4'hF;
	localparam logic [7:0] ORDER_INIT = 8'b11_10_01_00;

	// Galois LFSR, shifting right.
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		logic [15:0] s;
		s = {1'b0, v[15:1]};
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

	// Remainder of a 16-bit value by three, by folding digits of base 256, 16 and 4,
	// each of which is congruent to one.
	function automatic logic [1:0] mod3_16(input logic [15:0] x);
		logic [8:0] a;
		logic [5:0] b;
		logic [4:0] c;
		logic [2:0] d;
		logic [1:0] r;
		a = 9'(x[15:8]) + 9'(x[7:0]);
		b = 6'(a[8:4]) + 6'(a[3:0]);
		c = 5'(b[5:2]) + 5'(b[1:0]);
		d = 3'(c[4:2]) + 3'(c[1:0]);
		case (d)
			3'd1, 3'd4: r = 2'd1;
			3'd2, 3'd5: r = 2'd2;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/random_dfs_maze_generator.sv -----
// ============================================================================
// random_dfs_maze_generator - recursive backtracker maze generation
// Builds a maze on a configurable grid by a randomised depth-first walk with
// an explicit frame stack, and answers reads of single cells.
// ============================================================================
// A valid read item goes through the read-wait state and then the delivering state,
// which registers its result item; a faulted item of either kind goes straight to
// the delivering state. For a generate item the one walk sequencer makes three
// shuffle draws for each cell, tests each side in turn and returns through the frame
// stack by way of the load state. The block takes one item at a time.
// Reset is asynchronous, active low; it clears control state and visited marks.
// The wall store holds no reset value and is written as the walk enters cells.

module random_dfs_maze_generator #(
	parameter int MAX_ROWS    = rdfs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = rdfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [rdfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rdfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Command items.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [3:0] walk_row, [7:4] start_column, [15:8] cell_number
	input  logic [rdfs_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] func
	input  logic                             s_tuser,
	// Result items.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [3:0] wall_bits, [4] cell_seen, [7:5] zero
	output logic [rdfs_pkg::M_TDATA_W-1:0]   m_tdata,
	// [0] fault
	output logic                             m_tuser
);

	localparam int CELL_TOTAL = MAX_ROWS * MAX_COLUMNS;
	localparam int CELL_W     = $clog2(CELL_TOTAL);
	localparam int DEPTH_W    = $clog2(CELL_TOTAL + 1);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLUMNS);
	localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W     = $clog2(MAX_COLUMNS + 1);
	localparam int PROD_W     = RCNT_W + CCNT_W;

	// One frame of the walk: the cell, its position, the shuffled side order,
	// the next side to try and the walls of the cell as they stand so far.
	typedef struct packed {
		logic [CELL_W-1:0]     cell_id;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [3:0][1:0]       order;
		logic [2:0]            next;
		logic [3:0]            wall;
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SHUF,
		ST_STEP,
		ST_LOAD,
		ST_RDWAIT,
		ST_DELIVER
	} state_t;

	// Configuration registers.
	logic [rdfs_pkg::COUNT_W-1:0] row_count_q;
	logic [rdfs_pkg::COUNT_W-1:0] column_count_q;
	logic [rdfs_pkg::SEED_W-1:0]  random_seed_q;

	// Walk state.
	state_t                  state_q;
	frame_t                  top_q;
	logic [DEPTH_W-1:0]      depth_q;
	logic [1:0]              shuf_i_q;
	logic [15:0]             lfsr_q;
	logic [CELL_TOTAL-1:0]   visited_q;
	logic [ROW_W-1:0]        sr_q;
	logic [COL_W-1:0]        sc_q;

	// Pending result.
	logic [3:0]              res_wall_q;
	logic                    res_seen_q;
	logic                    res_fault_q;

	// Output register.
	logic                              m_tvalid_q;
	logic [rdfs_pkg::M_TDATA_W-1:0]    m_tdata_q;
	logic                              m_tuser_q;

	// Memories.
	logic [3:0]              wall_mem [CELL_TOTAL];
	frame_t                  stack_mem [CELL_TOTAL];
	logic [3:0]              wall_rdata_q;
	frame_t                  stk_rdata_q;

	// Input field unpacking.
	logic                    func;
	logic [3:0]              walk_row;
	logic [3:0]              start_column;
	logic [7:0]              cell_number;

	assign func         = s_tuser;
	assign walk_row     = s_tdata[3:0];
	assign start_column = s_tdata[7:4];
	assign cell_number  = s_tdata[15:8];

	// Effective grid size: the counts saturate at the parameter limits.
	logic [RCNT_W-1:0]       rows_eff;
	logic [CCNT_W-1:0]       cols_eff;
	logic [PROD_W-1:0]       grid_cells;
	logic                    start_bad;
	logic                    read_bad;
	logic [CELL_W+7:0]       cn_wide;
	logic [CELL_W-1:0]       rd_addr;
	logic [ROW_W+3:0]        sr_wide;
	logic [COL_W+3:0]        sc_wide;
	logic [PROD_W-1:0]       start_prod;
	logic                    accept;

	assign rows_eff = (32'(row_count_q) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
		: RCNT_W'(row_count_q);
	assign cols_eff = (32'(column_count_q) > MAX_COLUMNS) ? CCNT_W'(MAX_COLUMNS)
		: CCNT_W'(column_count_q);
	assign grid_cells = PROD_W'(rows_eff) * PROD_W'(cols_eff);

	assign start_bad = (32'(walk_row) >= 32'(rows_eff)) ||
		(32'(start_column) >= 32'(cols_eff));
	assign read_bad  = (32'(cell_number) >= 32'(grid_cells)) ||
		(32'(cell_number) >= CELL_TOTAL);

	assign cn_wide = (CELL_W + 8)'(cell_number);
	assign rd_addr = cn_wide[CELL_W-1:0];
	assign sr_wide = (ROW_W + 4)'(walk_row);
	assign sc_wide = (COL_W + 4)'(start_column);

	// The start cell's linear index.
	assign start_prod = PROD_W'(sr_q) * PROD_W'(cols_eff) + PROD_W'(sc_q);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Side test for the top frame. A single add or subtract forms the
	// neighbour's index: a row step moves by the column count, a column step by one.
	logic [1:0]              side;
	logic [1:0]              opp;
	logic [3:0]              side_mask;
	logic [3:0]              opp_mask;
	logic                    nb_ok;
	logic                    nb_sub;
	logic [CELL_W-1:0]       nb_delta;
	logic [CELL_W-1:0]       nb_cell;
	logic [ROW_W-1:0]        nb_row;
	logic [COL_W-1:0]        nb_col;
	logic                    nb_free;
	logic                    exhausted;
	logic                    descend;
	frame_t                  push_frame;
	frame_t                  nb_frame;

	assign side      = top_q.order[top_q.next[1:0]];
	assign opp       = side + 2'd2;
	assign side_mask = 4'b0001 << side;
	assign opp_mask  = 4'b0001 << opp;
	assign exhausted = top_q.next[2];

	always_comb begin
		nb_ok    = 1'b0;
		nb_sub   = 1'b0;
		nb_delta = CELL_W'(1);
		nb_row   = top_q.row;
		nb_col   = top_q.col;
		case (side)
			rdfs_pkg::SIDE_TOP: begin
				nb_ok    = (top_q.row != '0);
				nb_sub   = 1'b1;
				nb_delta = CELL_W'(cols_eff);
				nb_row   = top_q.row - ROW_W'(1);
			end
			rdfs_pkg::SIDE_LEFT: begin
				nb_ok    = (top_q.col != '0);
				nb_sub   = 1'b1;
				nb_col   = top_q.col - COL_W'(1);
			end
			rdfs_pkg::SIDE_BOTTOM: begin
				nb_ok    = ((ROW_W + 1)'(top_q.row) + (ROW_W + 1)'(1)) <
					(ROW_W + 1)'(rows_eff);
				nb_delta = CELL_W'(cols_eff);
				nb_row   = top_q.row + ROW_W'(1);
			end
			default: begin
				nb_ok    = ((COL_W + 1)'(top_q.col) + (COL_W + 1)'(1)) <
					(COL_W + 1)'(cols_eff);
				nb_col   = top_q.col + COL_W'(1);
			end
		endcase
	end

	assign nb_cell = nb_sub ? (top_q.cell_id - nb_delta) : (top_q.cell_id + nb_delta);
	assign nb_free = nb_ok && !visited_q[nb_cell];
	assign descend = (state_q == ST_STEP) && !exhausted && nb_free;

	always_comb begin
		push_frame      = top_q;
		push_frame.next = top_q.next + 3'd1;
		push_frame.wall = top_q.wall & ~side_mask;
	end

	always_comb begin
		nb_frame         = top_q;
		nb_frame.cell_id = nb_cell;
		nb_frame.row     = nb_row;
		nb_frame.col     = nb_col;
		nb_frame.order   = rdfs_pkg::ORDER_INIT;
		nb_frame.next    = 3'd0;
		nb_frame.wall    = rdfs_pkg::WALLS_ALL & ~opp_mask;
	end

	// Shuffle draw: step the LFSR, reduce it by i+1 and swap order[i] with order[j].
	logic [15:0]             lfsr_nx;
	logic [1:0]              shuf_j;
	logic [3:0][1:0]         shuf_order;

	assign lfsr_nx = rdfs_pkg::lfsr_step(lfsr_q);

	always_comb begin
		case (shuf_i_q)
			2'd3:    shuf_j = lfsr_nx[1:0];
			2'd2:    shuf_j = rdfs_pkg::mod3_16(lfsr_nx);
			default: shuf_j = {1'b0, lfsr_nx[0]};
		endcase
	end

	always_comb begin
		shuf_order           = top_q.order;
		shuf_order[shuf_i_q] = top_q.order[shuf_j];
		shuf_order[shuf_j]   = top_q.order[shuf_i_q];
	end

	// Memory ports. The top frame's walls are written when the walk enters a cell
	// and again each time a passage is opened from it, so the wall store never
	// needs reading during a walk.
	logic                    wall_we;
	logic [3:0]              wall_wdata;
	logic                    wall_re;
	logic [DEPTH_W-1:0]      depth_m1;
	logic [DEPTH_W-1:0]      depth_m2;

	assign wall_we    = descend || ((state_q == ST_SHUF) && (shuf_i_q == 2'd3));
	assign wall_wdata = (state_q == ST_SHUF) ? top_q.wall : push_frame.wall;
	assign wall_re    = accept && (func == rdfs_pkg::FUNC_READ);
	assign depth_m1   = depth_q - DEPTH_W'(1);
	assign depth_m2   = depth_q - DEPTH_W'(2);

	always_ff @(posedge clk) begin
		if (wall_we) begin
			wall_mem[top_q.cell_id] <= wall_wdata;
		end
		if (wall_re) begin
			wall_rdata_q <= wall_mem[rd_addr];
		end
	end

	// Frame stack: the top frame lives in registers, the frames below it here.
	always_ff @(posedge clk) begin
		if (descend) begin
			stack_mem[depth_m1[CELL_W-1:0]] <= push_frame;
		end
		stk_rdata_q <= stack_mem[depth_m2[CELL_W-1:0]];
	end

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= rdfs_pkg::ROW_COUNT_RST;
			column_count_q <= rdfs_pkg::COLUMN_COUNT_RST;
			random_seed_q  <= rdfs_pkg::RANDOM_SEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rdfs_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data[rdfs_pkg::COUNT_W-1:0];
				rdfs_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data[rdfs_pkg::COUNT_W-1:0];
				rdfs_pkg::REG_RANDOM_SEED:  random_seed_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: state, walk registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			depth_q     <= '0;
			shuf_i_q    <= '0;
			lfsr_q      <= 16'd1;
			visited_q   <= '0;
			sr_q        <= '0;
			sc_q        <= '0;
			res_wall_q  <= '0;
			res_seen_q  <= 1'b0;
			res_fault_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= 1'b0;
		end else begin
			// The delivering state reloads the output register itself.
			if (m_tvalid_q && m_tready && (state_q != ST_DELIVER)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_wall_q <= '0;
						if (func == rdfs_pkg::FUNC_GENERATE) begin
							res_seen_q  <= 1'b0;
							res_fault_q <= start_bad;
							if (start_bad) begin
								state_q <= ST_DELIVER;
							end else begin
								visited_q <= '0;
								lfsr_q    <= (random_seed_q == '0) ? 16'd1 : random_seed_q;
								sr_q      <= sr_wide[ROW_W-1:0];
								sc_q      <= sc_wide[COL_W-1:0];
								state_q   <= ST_START;
							end
						end else begin
							res_fault_q <= read_bad;
							res_seen_q  <= !read_bad && visited_q[rd_addr];
							state_q     <= read_bad ? ST_DELIVER : ST_RDWAIT;
						end
					end
				end
				ST_START: begin
					top_q.cell_id <= start_prod[CELL_W-1:0];
					top_q.row     <= sr_q;
					top_q.col     <= sc_q;
					top_q.order   <= rdfs_pkg::ORDER_INIT;
					top_q.next    <= 3'd0;
					top_q.wall    <= rdfs_pkg::WALLS_ALL;
					visited_q[start_prod[CELL_W-1:0]] <= 1'b1;
					depth_q       <= DEPTH_W'(1);
					shuf_i_q      <= 2'd3;
					state_q       <= ST_SHUF;
				end
				ST_SHUF: begin
					lfsr_q      <= lfsr_nx;
					top_q.order <= shuf_order;
					shuf_i_q    <= shuf_i_q - 2'd1;
					if (shuf_i_q == 2'd1) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exhausted) begin
						depth_q <= depth_m1;
						if (depth_q == DEPTH_W'(1)) begin
							state_q <= ST_DELIVER;
						end else begin
							state_q <= ST_LOAD;
						end
					end else if (nb_free) begin
						depth_q            <= depth_q + DEPTH_W'(1);
						top_q              <= nb_frame;
						visited_q[nb_cell] <= 1'b1;
						shuf_i_q           <= 2'd3;
						state_q            <= ST_SHUF;
					end else begin
						top_q.next <= top_q.next + 3'd1;
					end
				end
				ST_LOAD: begin
					top_q   <= stk_rdata_q;
					state_q <= ST_STEP;
				end
				ST_RDWAIT: begin
					res_wall_q <= wall_rdata_q;
					state_q    <= ST_DELIVER;
				end
				ST_DELIVER: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, res_seen_q, res_wall_q};
						m_tuser_q  <= res_fault_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- rtl/rdfs_checker.sv -----
// ============================================================================
// rdfs_checker - port-level checks for the maze generator
// Watches the stream ports of the top level over time; bound to it below.
// ============================================================================
module rdfs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rdfs_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// A held result keeps its payload until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// A faulted result carries no wall bits and no visited mark.
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("faulted result carries data");

	// The block takes one item at a time: it is busy right after an acceptance.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while still working");

	// A new result only appears when the block was busy in the cycle before.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work");

endmodule

bind random_dfs_maze_generator rdfs_checker u_rdfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
